/* rtl/kpcq_pkg.sv */
package kpcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int KEY_COUNT_DEF   = 4;

    localparam int CNT_W       = 8;
    localparam int KEY_W       = 3;
    localparam int LEVEL_W     = 4;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    typedef logic [1:0] lvl_sel_t;
    typedef logic [1:0] reg_idx_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [KEY_W-1:0] key_t;

    localparam reg_idx_t REG_SHORT_THRESHOLD  = 2'd0;
    localparam reg_idx_t REG_MEDIUM_THRESHOLD = 2'd1;
    localparam reg_idx_t REG_LONG_THRESHOLD   = 2'd2;
    localparam reg_idx_t REG_DEAD_TIME        = 2'd3;

    localparam count_t SHORT_THRESHOLD_RST  = 8'd3;
    localparam count_t MEDIUM_THRESHOLD_RST = 8'd50;
    localparam count_t LONG_THRESHOLD_RST   = 8'd150;
    localparam count_t DEAD_TIME_RST        = 8'd10;
    localparam count_t COUNT_MAX            = 8'd255;

    localparam key_t KEY_NONE = 3'd4;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_MEDIUM = 2'd2,
        EV_LONG   = 2'd3
    } ev_code_t;

    typedef struct packed {
        key_t     key;
        ev_code_t code;
    } event_t;

endpackage

/* rtl/key_press_classifier_queue_core.sv */
// Key press classifier with event queue. Each accepted word is either a sample tick that
// updates the press counters of KEY_COUNT keys (keys above 3 always read released) and
// pushes their short, medium or long events into a QUEUE_DEPTH-entry queue, or a read
// that pops one event; every word gives one result word, and irq_active is high while
// the queue holds events after that word. The block takes one word per cycle unless
// out_ready stalls the output: an input register feeds one pass of key and queue update
// logic, which loads the output register and the state together. The queue is a
// register file with one write port per key, so a tick can store up to KEY_COUNT events
// at once; events that find the queue full are dropped. The user writes thresholds and
// dead time over the APB port only while the block is idle; the block does not check it.
module key_press_classifier_queue_core #(
    parameter int QUEUE_DEPTH = kpcq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_COUNT   = kpcq_pkg::KEY_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [kpcq_pkg::LEVEL_W-1:0]  key_levels,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    event_code,
    output logic [kpcq_pkg::KEY_W-1:0]    key_index,
    output logic                          irq_active,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kpcq_pkg::ADDR_W-1:0]   paddr,
    input  logic [kpcq_pkg::DATA_W-1:0]   pwdata,
    output logic [kpcq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_LAST)
        begin
            res = '0;
        end
        else
        begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    // configuration registers
    kpcq_pkg::count_t short_threshold_reg;
    kpcq_pkg::count_t medium_threshold_reg;
    kpcq_pkg::count_t long_threshold_reg;
    kpcq_pkg::count_t dead_time_reg;

    // input stage
    logic                         in_valid_reg;
    logic                         func_reg;
    logic [kpcq_pkg::LEVEL_W-1:0] levels_reg;

    // output stage
    logic                         out_valid_reg;
    kpcq_pkg::ev_code_t           event_code_reg;
    kpcq_pkg::key_t               key_index_reg;
    logic                         irq_active_reg;

    // key state
    kpcq_pkg::count_t             press_counter_reg [KEY_COUNT];
    logic [KEY_COUNT-1:0]         fired_flag_reg;

    // event queue
    kpcq_pkg::event_t             event_store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]             write_pointer_reg;
    logic [PTR_W-1:0]             read_pointer_reg;
    logic [FILL_W-1:0]            fill_count_reg;

    // next values
    kpcq_pkg::count_t             press_counter_next [KEY_COUNT];
    logic [KEY_COUNT-1:0]         fired_flag_next;
    logic [KEY_COUNT-1:0]         push_ok;
    logic [PTR_W-1:0]             push_addr [KEY_COUNT];
    kpcq_pkg::event_t             push_data [KEY_COUNT];
    logic [PTR_W-1:0]             write_pointer_next;
    logic [PTR_W-1:0]             read_pointer_next;
    logic [FILL_W-1:0]            fill_count_next;
    kpcq_pkg::ev_code_t           event_code_next;
    kpcq_pkg::key_t               key_index_next;

    logic advance;
    logic do_item;
    logic do_tick;
    logic do_pop;
    logic cfg_write;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign do_item   = in_valid_reg && advance;
    assign do_tick   = do_item && !func_reg;
    assign do_pop    = do_item && func_reg && (fill_count_reg != '0);
    assign cfg_write = psel && penable && pwrite;

    assign out_valid  = out_valid_reg;
    assign event_code = event_code_reg;
    assign key_index  = key_index_reg;
    assign irq_active = irq_active_reg;
    assign pready     = 1'b1;

    // register read
    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            kpcq_pkg::REG_SHORT_THRESHOLD:  prdata[7:0] = short_threshold_reg;
            kpcq_pkg::REG_MEDIUM_THRESHOLD: prdata[7:0] = medium_threshold_reg;
            kpcq_pkg::REG_LONG_THRESHOLD:   prdata[7:0] = long_threshold_reg;
            kpcq_pkg::REG_DEAD_TIME:        prdata[7:0] = dead_time_reg;
            default:                        prdata = '0;
        endcase
    end

    // key update chain, index order, pushes packed behind the write pointer
    always_comb
    begin
        kpcq_pkg::count_t   cnt_v;
        logic               fired_v;
        logic               pressed_v;
        logic               push_v;
        kpcq_pkg::ev_code_t code_v;
        logic [FILL_W-1:0]  fill_v;
        logic [PTR_W-1:0]   wp_v;

        fill_v = fill_count_reg;
        wp_v   = write_pointer_reg;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            cnt_v     = press_counter_reg[k];
            fired_v   = fired_flag_reg[k];
            pressed_v = 1'b0;
            push_v    = 1'b0;
            code_v    = kpcq_pkg::EV_NONE;
            if (k < kpcq_pkg::LEVEL_W)
            begin
                pressed_v = levels_reg[kpcq_pkg::lvl_sel_t'(k)];
            end

            if (fired_v)
            begin
                if (!pressed_v)
                begin
                    if (cnt_v <= 8'd1)
                    begin
                        cnt_v   = '0;
                        fired_v = 1'b0;
                    end
                    else
                    begin
                        cnt_v = cnt_v - 1'b1;
                    end
                end
            end
            else if (pressed_v)
            begin
                if (cnt_v != kpcq_pkg::COUNT_MAX)
                begin
                    cnt_v = cnt_v + 1'b1;
                end
                if (cnt_v >= long_threshold_reg)
                begin
                    push_v  = 1'b1;
                    code_v  = kpcq_pkg::EV_LONG;
                    fired_v = 1'b1;
                    cnt_v   = dead_time_reg;
                end
            end
            else if (cnt_v < short_threshold_reg)
            begin
                if (cnt_v != '0)
                begin
                    cnt_v = cnt_v - 1'b1;
                end
            end
            else
            begin
                push_v = 1'b1;
                if (cnt_v >= long_threshold_reg)
                begin
                    code_v = kpcq_pkg::EV_LONG;
                end
                else if (cnt_v >= medium_threshold_reg)
                begin
                    code_v = kpcq_pkg::EV_MEDIUM;
                end
                else
                begin
                    code_v = kpcq_pkg::EV_SHORT;
                end
                fired_v = 1'b1;
                cnt_v   = dead_time_reg;
            end

            press_counter_next[k] = cnt_v;
            fired_flag_next[k]    = fired_v;
            push_ok[k]            = push_v && (fill_v < FILL_MAX);
            push_addr[k]          = wp_v;
            push_data[k].code     = code_v;
            push_data[k].key      = kpcq_pkg::key_t'(k);
            if (push_ok[k])
            begin
                fill_v = fill_v + 1'b1;
                wp_v   = ptr_inc(wp_v);
            end
        end

        write_pointer_next = write_pointer_reg;
        read_pointer_next  = read_pointer_reg;
        fill_count_next    = fill_count_reg;
        event_code_next    = kpcq_pkg::EV_NONE;
        key_index_next     = kpcq_pkg::KEY_NONE;
        if (do_tick)
        begin
            write_pointer_next = wp_v;
            fill_count_next    = fill_v;
        end
        else if (do_pop)
        begin
            read_pointer_next = ptr_inc(read_pointer_reg);
            fill_count_next   = fill_count_reg - 1'b1;
            event_code_next   = event_store_reg[read_pointer_reg].code;
            key_index_next    = event_store_reg[read_pointer_reg].key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_threshold_reg  <= kpcq_pkg::SHORT_THRESHOLD_RST;
            medium_threshold_reg <= kpcq_pkg::MEDIUM_THRESHOLD_RST;
            long_threshold_reg   <= kpcq_pkg::LONG_THRESHOLD_RST;
            dead_time_reg        <= kpcq_pkg::DEAD_TIME_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                kpcq_pkg::REG_SHORT_THRESHOLD:  short_threshold_reg  <= pwdata[7:0];
                kpcq_pkg::REG_MEDIUM_THRESHOLD: medium_threshold_reg <= pwdata[7:0];
                kpcq_pkg::REG_LONG_THRESHOLD:   long_threshold_reg   <= pwdata[7:0];
                kpcq_pkg::REG_DEAD_TIME:        dead_time_reg        <= pwdata[7:0];
                default:                        dead_time_reg        <= dead_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            fired_flag_reg    <= '0;
            write_pointer_reg <= '0;
            read_pointer_reg  <= '0;
            fill_count_reg    <= '0;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                press_counter_reg[k] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (do_tick)
            begin
                fired_flag_reg <= fired_flag_next;
                for (int k = 0; k < KEY_COUNT; k++)
                begin
                    press_counter_reg[k] <= press_counter_next[k];
                end
            end
            write_pointer_reg <= write_pointer_next;
            read_pointer_reg  <= read_pointer_next;
            fill_count_reg    <= fill_count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg   <= func;
            levels_reg <= key_levels;
        end
        if (do_item)
        begin
            event_code_reg <= event_code_next;
            key_index_reg  <= key_index_next;
            irq_active_reg <= (fill_count_next != '0);
        end
        if (do_tick)
        begin
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                if (push_ok[k])
                begin
                    event_store_reg[push_addr[k]] <= push_data[k];
                end
            end
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_MAX)
        else $error("event queue fill above depth");

    a_irq_follows_fill: assert property (@(posedge clk) disable iff (!rst_n)
        do_item |=> irq_active_reg == (fill_count_reg != '0))
        else $error("irq_active does not match queue fill");

    a_empty_read_none: assert property (@(posedge clk) disable iff (!rst_n)
        do_item && func_reg && (fill_count_reg == '0)
        |=> event_code_reg == kpcq_pkg::EV_NONE && key_index_reg == kpcq_pkg::KEY_NONE)
        else $error("read of empty queue returned an event");

    a_read_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        do_item && func_reg |=> fill_count_reg <= $past(fill_count_reg))
        else $error("queue fill grew on a read");

endmodule
